// File: sv/hst_pkg.sv
// Shared types, sizes and codes for the per-process handle slot table.
// Used by hst_pick and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hst_pkg;

  localparam int NUM_PROCS       = 16;
  localparam int WINDOW_SLOTS    = 32;
  localparam int FRAME_SLOTS     = 32;
  localparam int COMPONENT_SLOTS = 32;
  localparam int HANDLE_BITS     = 32;

  localparam int NTYPES    = 3;
  localparam int MAX_SLOTS = (WINDOW_SLOTS > FRAME_SLOTS) ?
                             ((WINDOW_SLOTS > COMPONENT_SLOTS) ? WINDOW_SLOTS : COMPONENT_SLOTS) :
                             ((FRAME_SLOTS > COMPONENT_SLOTS) ? FRAME_SLOTS : COMPONENT_SLOTS);
  localparam int TABLES    = NUM_PROCS * NTYPES;
  localparam int TAB_W     = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int HWM_W     = $clog2(MAX_SLOTS + 1);
  localparam int ROW_W     = HWM_W + MAX_SLOTS;
  localparam int HDEPTH    = TABLES * MAX_SLOTS;
  localparam int HADDR_W   = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_RM_ALL = 2'd2;
  localparam logic [1:0] MODE_FIND   = 2'd3;

  localparam logic [1:0] TYPE_WINDOW    = 2'd0;
  localparam logic [1:0] TYPE_FRAME     = 2'd1;
  localparam logic [1:0] TYPE_COMPONENT = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  pid;
    logic [1:0]  obj_type;
    logic [4:0]  slot_index;
    logic [31:0] handle_in;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [4:0]  slot_out;
    logic [31:0] handle_out;
  } rsp_t;

  // Row layout: {high-water mark, in-use bits}
  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [ROW_W-1:0]  row;
  } pick_t;

  function automatic logic [HWM_W-1:0] capacity(input logic [1:0] t);
    logic [HWM_W-1:0] c;
    case (t)
      TYPE_WINDOW:    c = HWM_W'(WINDOW_SLOTS);
      TYPE_FRAME:     c = HWM_W'(FRAME_SLOTS);
      TYPE_COMPONENT: c = HWM_W'(COMPONENT_SLOTS);
      default:        c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: sv/hst_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module hst_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/hst_pick.sv
// Slot allocation for one table row: high-water mark first, then first free slot.
// Depends on hst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hst_pick (
  input  wire logic [hst_pkg::ROW_W-1:0] row,
  input  wire logic [hst_pkg::HWM_W-1:0] cap,
  output hst_pkg::pick_t                 pick
);

  logic [hst_pkg::HWM_W-1:0]     hwm;
  logic [hst_pkg::HWM_W-1:0]     hwm_next;
  logic [hst_pkg::MAX_SLOTS-1:0] bits;
  logic [hst_pkg::MAX_SLOTS-1:0] bits_next;
  logic                          found;
  logic [hst_pkg::SLOT_W-1:0]    free_slot;

  assign hwm  = row[hst_pkg::ROW_W-1 -: hst_pkg::HWM_W];
  assign bits = row[hst_pkg::MAX_SLOTS-1:0];

  // lowest free slot below capacity
  always_comb begin
    found     = 1'b0;
    free_slot = '0;
    for (int s = hst_pkg::MAX_SLOTS - 1; s >= 0; s--) begin
      if ((s < int'(cap)) && !bits[s]) begin
        found     = 1'b1;
        free_slot = hst_pkg::SLOT_W'(s);
      end
    end
  end

  always_comb begin
    hwm_next  = hwm;
    bits_next = bits;
    pick.ok   = 1'b0;
    pick.slot = '0;
    if (hwm < cap) begin
      pick.ok   = 1'b1;
      pick.slot = hst_pkg::SLOT_W'(hwm);
      hwm_next  = hwm + 1'b1;
    end else if (found) begin
      pick.ok   = 1'b1;
      pick.slot = free_slot;
    end
    if (pick.ok) begin
      bits_next[pick.slot] = 1'b1;
    end
    pick.row = {hwm_next, bits_next};
  end

endmodule
`default_nettype wire

// File: sv/per_process_handle_slot_table_top.sv
// Top level of the per-process handle slot table: controller, row and handle RAMs.
// Depends on hst_pkg, hst_ram, hst_pick.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------
//  request | req_valid | req_stall | req (hst_pkg::req_t)
//  result  | rsp_valid | rsp_stall | rsp (hst_pkg::rsp_t)
//
// One request at a time: accept starts the registered row RAM read, the row state
// does the read-modify-write, find adds the handle RAM read state, and the output
// state loads the result register; a new request is taken only in idle. Reset empties
// every table at once through per-row valid flops; no clearing pass.
// A stalled result holds the block in its last state.
`timescale 1ns / 1ps
`default_nettype none
module per_process_handle_slot_table_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire hst_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output hst_pkg::rsp_t      rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ROW  = 2'd1;
  localparam logic [1:0] S_HND  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  hst_pkg::req_t               req_q;
  logic [hst_pkg::TAB_W-1:0]   tab_q;
  logic [hst_pkg::TAB_W-1:0]   tab_in;
  logic [hst_pkg::TABLES-1:0]  row_valid;
  hst_pkg::rsp_t               res;
  hst_pkg::rsp_t               res_next;

  logic                        row_we;
  logic [hst_pkg::ROW_W-1:0]   row_wdata;
  logic [hst_pkg::ROW_W-1:0]   row_rdata;
  logic [hst_pkg::ROW_W-1:0]   row;
  logic                        clr;
  logic [hst_pkg::TAB_W-1:0]   clr_base;

  logic                        hnd_we;
  logic [hst_pkg::HADDR_W-1:0] hnd_waddr;
  logic [hst_pkg::HADDR_W-1:0] hnd_raddr;
  logic [hst_pkg::HADDR_W-1:0] hnd_base;
  logic [hst_pkg::HANDLE_BITS-1:0] hnd_rdata;

  logic [hst_pkg::HWM_W-1:0]   cap;
  logic [hst_pkg::SLOT_W-1:0]  idx;
  logic                        pid_ok;
  logic                        type_ok;
  logic                        idx_ok;
  logic                        accept;
  hst_pkg::pick_t              pick;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);

  assign tab_in = hst_pkg::TAB_W'(req.pid) * hst_pkg::TAB_W'(hst_pkg::NTYPES)
                + hst_pkg::TAB_W'(req.obj_type);

  hst_ram #(
    .WIDTH (hst_pkg::ROW_W),
    .DEPTH (hst_pkg::TABLES),
    .ADDR_W(hst_pkg::TAB_W)
  ) u_row_ram (
    .clk  (clk),
    .we   (row_we),
    .waddr(tab_q),
    .wdata(row_wdata),
    .raddr(tab_in),
    .rdata(row_rdata)
  );

  assign hnd_base  = hst_pkg::HADDR_W'(tab_q) * hst_pkg::HADDR_W'(hst_pkg::MAX_SLOTS);
  assign hnd_waddr = hnd_base + hst_pkg::HADDR_W'(pick.slot);
  assign hnd_raddr = hnd_base + hst_pkg::HADDR_W'(idx);

  hst_ram #(
    .WIDTH (hst_pkg::HANDLE_BITS),
    .DEPTH (hst_pkg::HDEPTH),
    .ADDR_W(hst_pkg::HADDR_W)
  ) u_hnd_ram (
    .clk  (clk),
    .we   (hnd_we),
    .waddr(hnd_waddr),
    .wdata(hst_pkg::HANDLE_BITS'(req_q.handle_in)),
    .raddr(hnd_raddr),
    .rdata(hnd_rdata)
  );

  assign cap     = hst_pkg::capacity(req_q.obj_type);
  assign idx     = hst_pkg::SLOT_W'(req_q.slot_index);
  assign pid_ok  = int'(req_q.pid) < hst_pkg::NUM_PROCS;
  assign type_ok = int'(req_q.obj_type) < hst_pkg::NTYPES;
  assign idx_ok  = int'(req_q.slot_index) < int'(cap);
  assign row     = row_valid[tab_q] ? row_rdata : '0;
  assign clr_base = hst_pkg::TAB_W'(req_q.pid) * hst_pkg::TAB_W'(hst_pkg::NTYPES);

  hst_pick u_pick (
    .row (row),
    .cap (cap),
    .pick(pick)
  );

  always_comb begin
    state_next = state;
    res_next   = res;
    row_we     = 1'b0;
    row_wdata  = row;
    hnd_we     = 1'b0;
    clr        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_ROW;
        end
      end
      S_ROW: begin
        res_next   = '{status: hst_pkg::STATUS_FAIL, slot_out: '0, handle_out: '0};
        state_next = S_OUT;
        if (pid_ok) begin
          if (req_q.mode == hst_pkg::MODE_RM_ALL) begin
            clr             = 1'b1;
            res_next.status = hst_pkg::STATUS_OK;
          end else if (type_ok) begin
            unique case (req_q.mode)
              hst_pkg::MODE_ADD: begin
                if (pick.ok) begin
                  row_we            = 1'b1;
                  row_wdata         = pick.row;
                  hnd_we            = 1'b1;
                  res_next.status   = hst_pkg::STATUS_OK;
                  res_next.slot_out = 5'(pick.slot);
                end
              end
              hst_pkg::MODE_REMOVE: begin
                if (idx_ok && row[idx]) begin
                  row_we          = 1'b1;
                  row_wdata[idx]  = 1'b0;
                  res_next.status = hst_pkg::STATUS_OK;
                end
              end
              hst_pkg::MODE_FIND: begin
                if (idx_ok && row[idx]) begin
                  res_next.status = hst_pkg::STATUS_OK;
                  state_next      = S_HND;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_HND: begin
        res_next.handle_out = 32'(hnd_rdata);
        state_next          = S_OUT;
      end
      S_OUT: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_valid <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (row_we) begin
        row_valid[tab_q] <= 1'b1;
      end
      if (clr) begin
        for (int t = 0; t < hst_pkg::NTYPES; t++) begin
          row_valid[clr_base + hst_pkg::TAB_W'(t)] <= 1'b0;
        end
      end
      if (state == S_OUT && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
      tab_q <= tab_in;
    end
    res <= res_next;
    if (state == S_OUT && (!rsp_valid || !rsp_stall)) begin
      rsp <= res;
    end
  end

  a_hnd_write_with_row: assert property (@(posedge clk) disable iff (rst)
    hnd_we |-> (row_we && state == S_ROW))
    else $error("handle write without row update");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && $past(state) != S_IDLE) |-> rsp_valid)
    else $error("request retired without a result beat");

  a_hnd_after_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_HND) |-> ($past(state) == S_ROW))
    else $error("handle read state not entered from row state");

  a_accept_to_row: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_ROW))
    else $error("accepted request did not start row access");

endmodule
`default_nettype wire
